// ===== design/fixed_point_atan2_approx_defines.svh =====
// Assertion macros shared by the atan2 pipeline.
`ifndef FIXED_POINT_ATAN2_APPROX_DEFINES_SVH
`define FIXED_POINT_ATAN2_APPROX_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FPA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpa: assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpa: assertion failed");

`endif

// ===== design/fpa_pkg.sv =====
// Constants, codes and types shared by the atan2 pipeline and its channels.
package fpa_pkg;

    // Field widths of the channels.
    localparam int FIELD_W      = 18;
    localparam int ANGLE_W      = 17;
    localparam int IN_WIDTH_DEF = 18;

    // Ratio and cubic term arithmetic.
    localparam int FRAC         = 14;
    localparam int QW           = FRAC + 1;
    localparam int N_W          = QW + 1;
    localparam int SQ_W         = 2 * FRAC + 1;
    localparam int U_W          = FRAC + 2;
    localparam int CUBE_SHIFT   = 13;
    localparam int CUBE_ROUND   = (1 << CUBE_SHIFT) - 1;
    localparam int RECIP_W      = 16;
    localparam int RECIP_SHIFT  = 19;
    localparam int PROD_W       = U_W + RECIP_W;
    localparam int CMAG_W       = 12;
    localparam int CUBIC_STAGES = 6;

    // Reciprocal of nine, exact floor for every dividend up to 2^15.
    localparam logic [RECIP_W-1:0] RECIP9 = RECIP_W'(58255);

    // Angle offsets, 16384 per radian.
    localparam logic signed [ANGLE_W-1:0] PI_Q14      = ANGLE_W'(51472);
    localparam logic signed [ANGLE_W-1:0] HALF_PI_Q14 = ANGLE_W'(25736);

    // Sector codes.
    typedef logic [1:0] sector_t;
    localparam sector_t SECTOR_RIGHT = 2'd0;
    localparam sector_t SECTOR_LEFT  = 2'd1;
    localparam sector_t SECTOR_UP    = 2'd2;
    localparam sector_t SECTOR_DOWN  = 2'd3;

    // Per-item control carried alongside the arithmetic.
    typedef struct packed {
        sector_t sector;
        logic    ypos;
        logic    neg;
        logic    zero;
    } ctl_t;

endpackage

// ===== design/fpa_if.sv =====
// Valid/ready channel interfaces for the operand pair and the angle result.
interface fpa_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [fpa_pkg::FIELD_W-1:0]   y_value;
    logic signed [fpa_pkg::FIELD_W-1:0]   x_value;

    modport source (output valid, output y_value, output x_value, input ready);
    modport sink (input valid, input y_value, input x_value, output ready);
endinterface

interface fpa_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [fpa_pkg::ANGLE_W-1:0]   angle;

    modport source (output valid, output angle, input ready);
    modport sink (input valid, input angle, output ready);
endinterface

// ===== design/fixed_point_atan2_approx.sv =====
// Pipelined fixed-point atan2: operand pair in, phase angle (16384 per radian) out.
//
// Channels: sample carries y_value and x_value, result carries angle; a transfer
// happens on a rising clk edge with valid and ready both high. Only the low
// IN_WIDTH bits of each operand are used, sign-extended.
// The pipeline has 22 register stages: the front stage, then the restoring
// divider, which resolves one quotient bit per stage over 15 stages, then six
// stages for the cubic term (two multiplies, rounding, divide by nine, sum,
// offset). Throughput: one item per cycle while the receiver does not stall.
// Reset (rst_n low, asynchronous) clears every stage valid bit; the pipeline
// comes out of reset empty and ready.
// When the receiver stalls with a result waiting, the whole pipeline holds its
// contents. The front stage still takes one item while it is empty, so an item
// can be accepted while a finished result waits to be taken. Nothing is lost or
// repeated across a stall.
`include "fixed_point_atan2_approx_defines.svh"

module fixed_point_atan2_approx #(
    parameter int IN_WIDTH = fpa_pkg::IN_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    fpa_in_if.sink      sample,
    fpa_out_if.source   result
);

    localparam int W      = IN_WIDTH;
    localparam int QW     = fpa_pkg::QW;
    localparam int NST    = 1 + QW + fpa_pkg::CUBIC_STAGES;
    localparam int LAST   = NST - 1;
    localparam int C1     = QW + 1;
    localparam int C3     = QW + 3;
    localparam int TR_W   = fpa_pkg::SQ_W + 1;
    localparam logic [QW-1:0] Q_ONE = QW'(1 << fpa_pkg::FRAC);
    localparam logic [fpa_pkg::U_W-1:0] U_MAX = fpa_pkg::U_W'(1 << (fpa_pkg::FRAC + 1));

    // Pipeline control: one valid bit per stage, global advance.
    logic [NST-1:0] v_reg;
    logic [NST-1:0] v_next;
    logic           en;
    logic           fire;

    assign en           = ~v_reg[LAST] | result.ready;
    assign sample.ready = en | ~v_reg[0];
    assign fire         = sample.valid & sample.ready;

    always_comb
    begin
        v_next[0] = en ? fire : (v_reg[0] | fire);
        for (int i = 1; i < NST; i++)
        begin
            v_next[i] = en ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // Stage 0: magnitudes, sector selection and divider operands.
    logic [W-1:0]      y_raw;
    logic [W-1:0]      x_raw;
    logic              ysign;
    logic              xsign;
    logic [W-1:0]      ay;
    logic [W-1:0]      ax;
    logic              swap;
    logic [W-1:0]      s0_a_next;
    logic [W-1:0]      s0_b_next;
    fpa_pkg::ctl_t     s0_ctl_next;
    logic [W-1:0]      s0_a_reg;
    logic [W-1:0]      s0_b_reg;
    fpa_pkg::ctl_t     s0_ctl_reg;

    assign y_raw = sample.y_value[W-1:0];
    assign x_raw = sample.x_value[W-1:0];
    assign ysign = y_raw[W-1];
    assign xsign = x_raw[W-1];
    assign ay    = ysign ? (~y_raw + W'(1)) : y_raw;
    assign ax    = xsign ? (~x_raw + W'(1)) : x_raw;
    assign swap  = ay > ax;

    always_comb
    begin
        s0_a_next        = swap ? ax : ay;
        s0_b_next        = swap ? ay : ax;
        s0_ctl_next.zero = (ay == '0) && (ax == '0);
        s0_ctl_next.ypos = ~ysign && (ay != '0);
        s0_ctl_next.neg  = ysign ^ xsign;
        if (swap)
        begin
            s0_ctl_next.sector = ysign ? fpa_pkg::SECTOR_DOWN : fpa_pkg::SECTOR_UP;
        end
        else
        begin
            s0_ctl_next.sector = (~xsign && (ax != '0)) ? fpa_pkg::SECTOR_RIGHT
                                                        : fpa_pkg::SECTOR_LEFT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s0_a_reg   <= s0_a_next;
            s0_b_reg   <= s0_b_next;
            s0_ctl_reg <= s0_ctl_next;
        end
    end

    // Restoring divider: one quotient bit of (a << 14) / b per stage.
    logic [W-1:0]      div_rem_reg [QW];
    logic [W-1:0]      div_b_reg   [QW];
    logic [QW-1:0]     div_q_reg   [QW];
    fpa_pkg::ctl_t     div_ctl_reg [QW];

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        logic [W-1:0]  rem_in;
        logic [W-1:0]  b_in;
        logic [QW-1:0] q_in;
        fpa_pkg::ctl_t ctl_in;
        logic [W:0]    trial;
        logic          ge;
        logic [W-1:0]  rem_next;
        logic [QW-1:0] q_next;

        if (j == 0)
        begin : g_first
            assign rem_in = s0_a_reg;
            assign b_in   = s0_b_reg;
            assign q_in   = '0;
            assign ctl_in = s0_ctl_reg;
            assign trial  = {1'b0, rem_in};
        end
        else
        begin : g_rest
            assign rem_in = div_rem_reg[j-1];
            assign b_in   = div_b_reg[j-1];
            assign q_in   = div_q_reg[j-1];
            assign ctl_in = div_ctl_reg[j-1];
            assign trial  = {rem_in, 1'b0};
        end

        assign ge       = trial >= {1'b0, b_in};
        assign rem_next = ge ? W'(trial - {1'b0, b_in}) : trial[W-1:0];
        assign q_next   = {q_in[QW-2:0], ge};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_rem_reg[j] <= rem_next;
                div_b_reg[j]   <= b_in;
                div_q_reg[j]   <= q_next;
                div_ctl_reg[j] <= ctl_in;
            end
        end
    end

    // Cubic stage 1: signed ratio and its square.
    logic [QW-1:0]                    q_fin;
    logic signed [fpa_pkg::N_W-1:0]   q_s;
    logic [2*QW-1:0]                  sq_full;
    logic signed [fpa_pkg::N_W-1:0]   c1_n_next;
    logic [fpa_pkg::SQ_W-1:0]         c1_sq_next;
    logic signed [fpa_pkg::N_W-1:0]   c1_n_reg;
    logic [QW-1:0]                    c1_m_reg;
    logic [fpa_pkg::SQ_W-1:0]         c1_sq_reg;
    fpa_pkg::ctl_t                    c1_ctl_reg;

    assign q_fin      = div_q_reg[QW-1];
    assign q_s        = {1'b0, q_fin};
    assign c1_n_next  = div_ctl_reg[QW-1].neg ? -q_s : q_s;
    assign sq_full    = q_fin * q_fin;
    assign c1_sq_next = sq_full[fpa_pkg::SQ_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_n_reg   <= c1_n_next;
            c1_m_reg   <= q_fin;
            c1_sq_reg  <= c1_sq_next;
            c1_ctl_reg <= div_ctl_reg[QW-1];
        end
    end

    // Cubic stage 2: (n*n >> 14) * |n|.
    logic [QW-1:0]                    p_sq;
    logic [2*QW-1:0]                  t_full;
    logic [fpa_pkg::SQ_W-1:0]         c2_t_next;
    logic [fpa_pkg::SQ_W-1:0]         c2_t_reg;
    logic signed [fpa_pkg::N_W-1:0]   c2_n_reg;
    fpa_pkg::ctl_t                    c2_ctl_reg;

    assign p_sq      = c1_sq_reg[fpa_pkg::SQ_W-1:fpa_pkg::FRAC];
    assign t_full    = p_sq * c1_m_reg;
    assign c2_t_next = t_full[fpa_pkg::SQ_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c2_t_reg   <= c2_t_next;
            c2_n_reg   <= c1_n_reg;
            c2_ctl_reg <= c1_ctl_reg;
        end
    end

    // Cubic stage 3: shift by 13, rounding up in magnitude for a negative ratio.
    logic [TR_W-1:0]                  t_round;
    logic [fpa_pkg::U_W-1:0]          c3_u_next;
    logic [fpa_pkg::U_W-1:0]          c3_u_reg;
    logic signed [fpa_pkg::N_W-1:0]   c3_n_reg;
    fpa_pkg::ctl_t                    c3_ctl_reg;

    assign t_round   = c2_ctl_reg.neg ? ({1'b0, c2_t_reg} + TR_W'(fpa_pkg::CUBE_ROUND))
                                      : {1'b0, c2_t_reg};
    assign c3_u_next = t_round[fpa_pkg::CUBE_SHIFT+fpa_pkg::U_W-1:fpa_pkg::CUBE_SHIFT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c3_u_reg   <= c3_u_next;
            c3_n_reg   <= c2_n_reg;
            c3_ctl_reg <= c2_ctl_reg;
        end
    end

    // Cubic stage 4: divide by nine through the reciprocal.
    logic [fpa_pkg::PROD_W-1:0]       c4_prod_next;
    logic [fpa_pkg::PROD_W-1:0]       c4_prod_reg;
    logic signed [fpa_pkg::N_W-1:0]   c4_n_reg;
    fpa_pkg::ctl_t                    c4_ctl_reg;

    assign c4_prod_next = fpa_pkg::PROD_W'(c3_u_reg) * fpa_pkg::PROD_W'(fpa_pkg::RECIP9);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c4_prod_reg <= c4_prod_next;
            c4_n_reg    <= c3_n_reg;
            c4_ctl_reg  <= c3_ctl_reg;
        end
    end

    // Cubic stage 5: r = n - cubic(n), cubic term signed like n.
    logic [fpa_pkg::CMAG_W-1:0]           cmag;
    logic signed [fpa_pkg::ANGLE_W-1:0]   cmag_s;
    logic signed [fpa_pkg::ANGLE_W-1:0]   cube;
    logic signed [fpa_pkg::ANGLE_W-1:0]   n_ext;
    logic signed [fpa_pkg::ANGLE_W-1:0]   c5_r_next;
    logic signed [fpa_pkg::ANGLE_W-1:0]   c5_r_reg;
    fpa_pkg::ctl_t                        c5_ctl_reg;

    assign cmag      = c4_prod_reg[fpa_pkg::RECIP_SHIFT+fpa_pkg::CMAG_W-1:fpa_pkg::RECIP_SHIFT];
    assign cmag_s    = fpa_pkg::ANGLE_W'(cmag);
    assign cube      = c4_ctl_reg.neg ? -cmag_s : cmag_s;
    assign n_ext     = fpa_pkg::ANGLE_W'(c4_n_reg);
    assign c5_r_next = n_ext - cube;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c5_r_reg   <= c5_r_next;
            c5_ctl_reg <= c4_ctl_reg;
        end
    end

    // Stage 6: sector offsets and the all-zero case; output register.
    logic signed [fpa_pkg::ANGLE_W-1:0]   angle_next;
    logic signed [fpa_pkg::ANGLE_W-1:0]   angle_reg;

    always_comb
    begin
        case (c5_ctl_reg.sector)
            fpa_pkg::SECTOR_RIGHT:
            begin
                angle_next = c5_r_reg;
            end
            fpa_pkg::SECTOR_LEFT:
            begin
                angle_next = c5_ctl_reg.ypos ? (c5_r_reg + fpa_pkg::PI_Q14)
                                             : (c5_r_reg - fpa_pkg::PI_Q14);
            end
            fpa_pkg::SECTOR_UP:
            begin
                angle_next = fpa_pkg::HALF_PI_Q14 - c5_r_reg;
            end
            fpa_pkg::SECTOR_DOWN:
            begin
                angle_next = -c5_r_reg - fpa_pkg::HALF_PI_Q14;
            end
            default:
            begin
                angle_next = c5_r_reg;
            end
        endcase
        if (c5_ctl_reg.zero)
        begin
            angle_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= angle_next;
        end
    end

    assign result.valid = v_reg[LAST];
    assign result.angle = angle_reg;

    // Checks on the pipeline's own arithmetic and stall handling.
    `FPA_ASSERT_IMPL(a_angle_range, result.valid, (result.angle <= fpa_pkg::PI_Q14) && (result.angle >= -fpa_pkg::PI_Q14))
    `FPA_ASSERT_IMPL(a_quot_bound, v_reg[QW] && !div_ctl_reg[QW-1].zero, div_q_reg[QW-1] <= Q_ONE)
    `FPA_ASSERT_IMPL(a_round_bound, v_reg[C3] && !c3_ctl_reg.zero, c3_u_reg <= U_MAX)
    `FPA_ASSERT_NEXT(a_front_hold, v_reg[0] && !en && v_reg[C1 - QW - 1], v_reg[0])

endmodule
